@@ rtl/cbod_pkg.sv @@
// Shared constants, register codes and types for the cluster box obstacle detector.
// No dependencies; imported by every module of the block.
package cbod_pkg;

    localparam int MAX_CLUSTERS  = 64;
    localparam int SLOT_BITS     = $clog2(MAX_CLUSTERS);
    localparam int USED_BITS     = SLOT_BITS + 1;
    localparam int COUNT_BITS    = 17;
    localparam int COORD_BITS    = 20;
    localparam int CMP_BITS      = COORD_BITS + 1;
    localparam int LABEL_BITS    = 16;
    localparam int LIM_BITS      = 19;
    localparam int THR_BITS      = 17;
    localparam int OUT_SLOT_BITS = 6;
    localparam int OUT_CNT_BITS  = 17;
    localparam int NUM_REGS      = 5;
    localparam int ADDR_BITS     = $clog2(4 * NUM_REGS);
    localparam int DATA_BITS     = 32;
    localparam int IN_BYTES_BITS = 80;
    localparam int OUT_DATA_BITS = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [ADDR_BITS-3:0] t_reg_idx;
    localparam t_reg_idx REG_X_LIMIT = t_reg_idx'(0);
    localparam t_reg_idx REG_Y_LIMIT = t_reg_idx'(1);
    localparam t_reg_idx REG_Z_HIGH  = t_reg_idx'(2);
    localparam t_reg_idx REG_Z_LOW   = t_reg_idx'(3);
    localparam t_reg_idx REG_THRESH  = t_reg_idx'(4);

    localparam logic [LIM_BITS-1:0]          RST_X_LIMIT = LIM_BITS'(2500);
    localparam logic [LIM_BITS-1:0]          RST_Y_LIMIT = LIM_BITS'(700);
    localparam logic signed [COORD_BITS-1:0] RST_Z_HIGH  = COORD_BITS'(2000);
    localparam logic signed [COORD_BITS-1:0] RST_Z_LOW   = -COORD_BITS'(500);
    localparam logic [THR_BITS-1:0]          RST_THRESH  = THR_BITS'(100);

    typedef struct packed {
        logic [LIM_BITS-1:0]          x_limit;
        logic [LIM_BITS-1:0]          y_limit;
        logic signed [COORD_BITS-1:0] z_high;
        logic signed [COORD_BITS-1:0] z_low;
        logic [THR_BITS-1:0]          count_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_mm;
        logic signed [COORD_BITS-1:0] y_mm;
        logic signed [COORD_BITS-1:0] z_mm;
        logic [LABEL_BITS-1:0]        seg_label;
        logic                         frame_end;
    } t_point;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [COUNT_BITS-1:0] count;
    } t_slot;

    typedef struct packed {
        logic load;
        logic search;
        logic scan_start;
        logic scan;
        logic report;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/cluster_box_obstacle_detect.sv @@
// Each point item is matched against the cluster slots of the current frame by a pipelined
// search of the slot memory, one slot per cycle. The search stops at the slot that holds its
// label, or after all taken slots when the label is new. The item with tlast then scans
// the taken slots on the same memory port until one reports or none is left, and then the
// result register is loaded; that load waits until any earlier result has left. The next
// point is accepted after that load while the new result may still wait on m_tready.
// The slot memory of 64 slots needs no clearing pass: only slots below the fill count are
// ever read. Depends on cbod_pkg, cbod_regs, cbod_datapath and cbod_ctrl.
module cluster_box_obstacle_detect (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_mm[19:0], y_mm[39:20], z_mm[59:40], seg_label[75:60], zero fill[79:76]
    input  logic [cbod_pkg::IN_BYTES_BITS-1:0]   s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // cluster_slot[5:0], box_count[22:6], slot_overflow[23]
    output logic [cbod_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // obstacle[0]
    output logic [0:0]                           m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbod_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [cbod_pkg::DATA_BITS-1:0]       pwdata,
    output logic [cbod_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);
    import cbod_pkg::*;

    t_cfg                     w_cfg;
    t_point                   w_point;
    t_dp_cmd                  w_cmd;
    t_dp_sts                  w_sts;
    logic [OUT_SLOT_BITS-1:0] w_slot;
    logic [OUT_CNT_BITS-1:0]  w_count;
    logic                     w_ovf;

    assign pready = 1'b1;

    assign w_point.x_mm      = signed'(s_tdata[19:0]);
    assign w_point.y_mm      = signed'(s_tdata[39:20]);
    assign w_point.z_mm      = signed'(s_tdata[59:40]);
    assign w_point.seg_label = s_tdata[75:60];
    assign w_point.frame_end = s_tlast;

    cbod_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    cbod_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cbod_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_point         (w_point),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_m_tready      (m_tready),
        .o_m_tvalid      (m_tvalid),
        .o_obstacle      (m_tuser[0]),
        .o_cluster_slot  (w_slot),
        .o_box_count     (w_count),
        .o_slot_overflow (w_ovf)
    );

    assign m_tdata = {w_ovf, w_count, w_slot};

endmodule

@@ rtl/cbod_regs.sv @@
// APB register file holding the box bounds and count threshold.
// Depends on cbod_pkg.
module cbod_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [cbod_pkg::ADDR_BITS-1:0]  i_paddr,
    input  logic [cbod_pkg::DATA_BITS-1:0]  i_pwdata,
    output logic [cbod_pkg::DATA_BITS-1:0]  o_prdata,
    output cbod_pkg::t_cfg                  o_cfg
);
    import cbod_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;

    assign w_idx = i_paddr[ADDR_BITS-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (i_psel && i_penable && i_pwrite) begin
            case (w_idx)
                REG_X_LIMIT: n_cfg.x_limit         = i_pwdata[LIM_BITS-1:0];
                REG_Y_LIMIT: n_cfg.y_limit         = i_pwdata[LIM_BITS-1:0];
                REG_Z_HIGH:  n_cfg.z_high          = signed'(i_pwdata[COORD_BITS-1:0]);
                REG_Z_LOW:   n_cfg.z_low           = signed'(i_pwdata[COORD_BITS-1:0]);
                REG_THRESH:  n_cfg.count_threshold = i_pwdata[THR_BITS-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_X_LIMIT: o_prdata = DATA_BITS'(r_cfg.x_limit);
            REG_Y_LIMIT: o_prdata = DATA_BITS'(r_cfg.y_limit);
            REG_Z_HIGH:  o_prdata = DATA_BITS'(r_cfg.z_high);
            REG_Z_LOW:   o_prdata = DATA_BITS'(r_cfg.z_low);
            REG_THRESH:  o_prdata = DATA_BITS'(r_cfg.count_threshold);
            default:     o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_limit         <= RST_X_LIMIT;
            r_cfg.y_limit         <= RST_Y_LIMIT;
            r_cfg.z_high          <= RST_Z_HIGH;
            r_cfg.z_low           <= RST_Z_LOW;
            r_cfg.count_threshold <= RST_THRESH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/cbod_datapath.sv @@
// Datapath: point register, slot memory with pipelined search/scan, counters, result register.
// Depends on cbod_pkg; sequenced by cbod_ctrl.
module cbod_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cbod_pkg::t_cfg                       i_cfg,
    input  cbod_pkg::t_point                     i_point,
    input  cbod_pkg::t_dp_cmd                    i_cmd,
    output cbod_pkg::t_dp_sts                    o_sts,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic                                 o_obstacle,
    output logic [cbod_pkg::OUT_SLOT_BITS-1:0]   o_cluster_slot,
    output logic [cbod_pkg::OUT_CNT_BITS-1:0]    o_box_count,
    output logic                                 o_slot_overflow
);
    import cbod_pkg::*;

    t_slot r_mem [MAX_CLUSTERS];
    t_slot r_rdata;

    t_point                 r_pt;
    logic [USED_BITS-1:0]   r_ridx,  n_ridx;
    logic                   r_rv,    n_rv;
    logic [SLOT_BITS-1:0]   r_cidx,  n_cidx;
    logic [USED_BITS-1:0]   r_used,  n_used;
    logic                   r_ovf,   n_ovf;
    logic                   r_hobst, n_hobst;
    logic [SLOT_BITS-1:0]   r_hslot, n_hslot;
    logic [COUNT_BITS-1:0]  r_hcnt,  n_hcnt;
    logic                   r_ovalid, n_ovalid;
    logic                   r_oobst;
    logic [SLOT_BITS-1:0]   r_oslot;
    logic [COUNT_BITS-1:0]  r_ocnt;
    logic                   r_oovf;

    logic                   w_run, w_hit, w_miss, w_issue, w_inside, w_inc, w_we;
    logic [SLOT_BITS-1:0]   w_waddr;
    t_slot                  w_wdata;
    logic signed [CMP_BITS-1:0] w_x, w_y, w_xl, w_yl;

    assign w_x  = CMP_BITS'(r_pt.x_mm);
    assign w_y  = CMP_BITS'(r_pt.y_mm);
    assign w_xl = signed'(CMP_BITS'(i_cfg.x_limit));
    assign w_yl = signed'(CMP_BITS'(i_cfg.y_limit));

    assign w_inside = (r_pt.x_mm > 0) && (w_x < w_xl) && (w_y < w_yl) && (w_y > -w_yl)
                   && (r_pt.z_mm > i_cfg.z_low) && (r_pt.z_mm < i_cfg.z_high);
    assign w_inc    = w_inside && (r_rdata.count != COUNT_MAX);

    assign w_run   = i_cmd.search | i_cmd.scan;
    assign w_hit   = r_rv && (i_cmd.scan ? (r_rdata.count > i_cfg.count_threshold)
                                         : (r_rdata.label == r_pt.seg_label));
    assign w_miss  = !r_rv && (r_ridx >= r_used);
    assign w_issue = w_run && !w_hit && (r_ridx < r_used);

    always_comb begin
        n_ridx   = r_ridx;
        n_rv     = w_issue;
        n_cidx   = r_cidx;
        n_used   = r_used;
        n_ovf    = r_ovf;
        n_hobst  = r_hobst;
        n_hslot  = r_hslot;
        n_hcnt   = r_hcnt;
        n_ovalid = r_ovalid;
        w_we     = 1'b0;
        w_waddr  = r_cidx;
        w_wdata  = '{label: r_pt.seg_label, count: r_rdata.count + COUNT_BITS'(w_inc)};

        if (w_issue) begin
            n_ridx = r_ridx + USED_BITS'(1);
            n_cidx = r_ridx[SLOT_BITS-1:0];
        end

        if (i_cmd.search && w_hit) begin
            w_we = 1'b1;
        end else if (i_cmd.search && w_miss) begin
            if (r_used != USED_BITS'(MAX_CLUSTERS)) begin
                w_we    = 1'b1;
                w_waddr = r_used[SLOT_BITS-1:0];
                w_wdata = '{label: r_pt.seg_label, count: COUNT_BITS'(w_inside)};
                n_used  = r_used + USED_BITS'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_cmd.scan && (w_hit || w_miss)) begin
            n_hobst = w_hit;
            n_hslot = w_hit ? r_cidx : '0;
            n_hcnt  = w_hit ? r_rdata.count : '0;
        end

        if (i_cmd.load || i_cmd.scan_start) begin
            n_ridx = '0;
            n_rv   = 1'b0;
        end

        if (i_cmd.report) begin
            n_ovalid = 1'b1;
            n_used   = '0;
            n_ovf    = 1'b0;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rdata <= r_mem[r_ridx[SLOT_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt <= i_point;
        end
        if (i_cmd.report) begin
            r_oobst <= r_hobst;
            r_oslot <= r_hslot;
            r_ocnt  <= r_hcnt;
            r_oovf  <= r_ovf;
        end
        r_cidx  <= n_cidx;
        r_hobst <= n_hobst;
        r_hslot <= n_hslot;
        r_hcnt  <= n_hcnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx   <= '0;
            r_rv     <= 1'b0;
            r_used   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ridx   <= n_ridx;
            r_rv     <= n_rv;
            r_used   <= n_used;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_sts.hit      = w_hit;
    assign o_sts.miss     = w_miss;
    assign o_sts.last     = r_pt.frame_end;
    assign o_sts.out_free = !r_ovalid || i_m_tready;

    assign o_m_tvalid      = r_ovalid;
    assign o_obstacle      = r_oobst;
    assign o_cluster_slot  = OUT_SLOT_BITS'(r_oslot);
    assign o_box_count     = OUT_CNT_BITS'(r_ocnt);
    assign o_slot_overflow = r_oovf;

endmodule

@@ rtl/cbod_ctrl.sv @@
// Controller state machine: sequences accept, label search, end-of-frame scan and report.
// Depends on cbod_pkg; drives cbod_datapath.
module cbod_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  cbod_pkg::t_dp_sts    i_sts,
    output cbod_pkg::t_dp_cmd    o_cmd
);
    import cbod_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SCAN   = 4'b0100,
        S_REPORT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    if (i_sts.last) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/cbod_checker.sv @@
// Port-level checks for cluster_box_obstacle_detect, attached by bind.
// Depends on cbod_pkg.
module cbod_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [cbod_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input logic [0:0]                          m_tuser
);
    import cbod_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted during search");

    a_no_obstacle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[OUT_SLOT_BITS+OUT_CNT_BITS-1:0] == '0)
        else $error("slot or count set without obstacle");

    a_obstacle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[OUT_SLOT_BITS+OUT_CNT_BITS-1:OUT_SLOT_BITS] != '0)
        else $error("obstacle reported with zero count");

endmodule

bind cluster_box_obstacle_detect cbod_checker u_cbod_checker (.*);

@@ tb/cluster_box_obstacle_detect_tb.sv @@
// Self-checking bench for cluster_box_obstacle_detect: directed point table, then random
// frames under several box settings and idling modes, checked by a local predictor.
// Depends on cbod_pkg and the cluster_box_obstacle_detect RTL.
module cluster_box_obstacle_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbod_pkg::*;

    localparam int       DRAIN_CYCLES = 160;
    localparam int       DRAIN_LIMIT  = 50000;
    localparam int       PHASE_POINTS = 95;
    localparam t_reg_idx REG_SPARE    = t_reg_idx'(NUM_REGS);

    typedef enum { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;
    typedef enum { FRAME_SPARSE, FRAME_DENSE, FRAME_CROWDED } t_frame_kind;

    typedef struct packed {
        logic                     obstacle;
        logic [OUT_SLOT_BITS-1:0] slot;
        logic [OUT_CNT_BITS-1:0]  count;
        logic                     overflow;
    } t_det_report;

    typedef struct {
        bit          is_cfg;
        t_reg_idx    reg_idx;
        logic [31:0] value;
        t_point      pt;
        bit          typed;
        t_det_report want;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_BYTES_BITS-1:0] s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [0:0]               m_tuser;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_BITS-1:0]     paddr = '0;
    logic [DATA_BITS-1:0]     pwdata = '0;
    logic [DATA_BITS-1:0]     prdata;
    logic                     pready;

    cluster_box_obstacle_detect u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    t_cfg                  box_cfg = {RST_X_LIMIT, RST_Y_LIMIT, RST_Z_HIGH, RST_Z_LOW, RST_THRESH};
    logic [LABEL_BITS-1:0] slot_label [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] slot_tally [MAX_CLUSTERS];
    int                    slots_taken = 0;
    bit                    label_dropped = 1'b0;

    t_det_report expected_reports[$];
    t_stim_row   dir_rows[$];
    int          sender_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    int          points_sent = 0;
    int          frames_closed = 0;
    int          obstacle_frames = 0;
    int          overflow_frames = 0;

    function automatic t_det_report take_point(t_point p);
        int x, y, z, xl, yl, zl, zh, hit;
        bit in_box;
        t_det_report rep;
        x = $signed(p.x_mm);
        y = $signed(p.y_mm);
        z = $signed(p.z_mm);
        xl = int'(box_cfg.x_limit);
        yl = int'(box_cfg.y_limit);
        zl = $signed(box_cfg.z_low);
        zh = $signed(box_cfg.z_high);
        hit = -1;
        for (int i = 0; i < slots_taken; i++) begin
            if (hit < 0 && slot_label[i] == p.seg_label) hit = i;
        end
        if (hit < 0) begin
            if (slots_taken < MAX_CLUSTERS) begin
                hit = slots_taken;
                slot_label[hit] = p.seg_label;
                slot_tally[hit] = '0;
                slots_taken++;
            end else begin
                label_dropped = 1'b1;
            end
        end
        in_box = x > 0 && x < xl && y < yl && y > -yl && z > zl && z < zh;
        if (hit >= 0 && in_box && slot_tally[hit] != COUNT_MAX) slot_tally[hit]++;
        rep = '0;
        if (p.frame_end) begin
            rep.overflow = label_dropped;
            for (int i = 0; i < slots_taken; i++) begin
                if (!rep.obstacle && slot_tally[i] > box_cfg.count_threshold) begin
                    rep.obstacle = 1'b1;
                    rep.slot = OUT_SLOT_BITS'(i);
                    rep.count = OUT_CNT_BITS'(slot_tally[i]);
                end
            end
            slots_taken = 0;
            label_dropped = 1'b0;
        end
        return rep;
    endfunction

    function automatic void set_reg(t_reg_idx idx, logic [31:0] v);
        case (idx)
            REG_X_LIMIT: box_cfg.x_limit = v[LIM_BITS-1:0];
            REG_Y_LIMIT: box_cfg.y_limit = v[LIM_BITS-1:0];
            REG_Z_HIGH:  box_cfg.z_high = v[COORD_BITS-1:0];
            REG_Z_LOW:   box_cfg.z_low = v[COORD_BITS-1:0];
            REG_THRESH:  box_cfg.count_threshold = v[THR_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_field(t_reg_idx idx, logic [31:0] v);
        case (idx)
            REG_X_LIMIT, REG_Y_LIMIT: return v & 32'h7FFFF;
            REG_Z_HIGH, REG_Z_LOW:    return v & 32'hFFFFF;
            default:                  return v & 32'h1FFFF;
        endcase
    endfunction

    function automatic logic [31:0] cfg_word(t_reg_idx idx);
        case (idx)
            REG_X_LIMIT: return {13'b0, box_cfg.x_limit};
            REG_Y_LIMIT: return {13'b0, box_cfg.y_limit};
            REG_Z_HIGH:  return {12'b0, box_cfg.z_high};
            REG_Z_LOW:   return {12'b0, box_cfg.z_low};
            default:     return {15'b0, box_cfg.count_threshold};
        endcase
    endfunction

    function automatic logic [31:0] dirty(int v, int w);
        return ($urandom << w) | (32'(v) & ((32'd1 << w) - 32'd1));
    endfunction

    function automatic t_stim_row pt_row(int x, int y, int z, int lab, bit last,
                                         bit typed = 1'b0, t_det_report want = '0);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.reg_idx = REG_X_LIMIT;
        r.value = '0;
        r.pt.x_mm = x[COORD_BITS-1:0];
        r.pt.y_mm = y[COORD_BITS-1:0];
        r.pt.z_mm = z[COORD_BITS-1:0];
        r.pt.seg_label = lab[LABEL_BITS-1:0];
        r.pt.frame_end = last;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(t_reg_idx idx, int v);
        t_stim_row r;
        r = pt_row(0, 0, 0, 0, 1'b0);
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = 32'(v);
        return r;
    endfunction

    function automatic void add_row(t_stim_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic t_point rand_point(logic [LABEL_BITS-1:0] lab, bit dense);
        t_point p;
        int r, x, y, z, xl, yl, zl, zh;
        xl = int'(box_cfg.x_limit);
        yl = int'(box_cfg.y_limit);
        zl = $signed(box_cfg.z_low);
        zh = $signed(box_cfg.z_high);
        r = $urandom_range(0, 99);
        if (!dense && r < 35) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
        end else if (r < 45) begin
            case ($urandom_range(0, 3))
                0: x = 0;
                1: x = 1;
                2: x = xl - 1;
                default: x = xl;
            endcase
            case ($urandom_range(0, 3))
                0: y = yl;
                1: y = yl - 1;
                2: y = -yl;
                default: y = 1 - yl;
            endcase
            case ($urandom_range(0, 3))
                0: z = zl;
                1: z = zl + 1;
                2: z = zh - 1;
                default: z = zh;
            endcase
        end else begin
            x = int'($urandom_range(0, 3200)) - 200;
            y = int'($urandom_range(0, 1800)) - 900;
            z = int'($urandom_range(0, 2800)) - 700;
        end
        p.x_mm = x[COORD_BITS-1:0];
        p.y_mm = y[COORD_BITS-1:0];
        p.z_mm = z[COORD_BITS-1:0];
        p.seg_label = lab;
        p.frame_end = 1'b0;
        return p;
    endfunction

    task automatic set_idling(t_idle_mode mode);
        sender_gap_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 8 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 8 : 0;
    endtask

    task automatic apb_xfer(bit wr, t_reg_idx idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, v, unused);
        set_reg(idx, v);
    endtask

    task automatic check_regs();
        logic [31:0] rd;
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_xfer(1'b0, t_reg_idx'(i), '0, rd);
            if (reg_field(t_reg_idx'(i), rd) !== cfg_word(t_reg_idx'(i))) begin
                errors++;
                $display("%0t register %0d: expected %0h got %0h", $time, i,
                         cfg_word(t_reg_idx'(i)), reg_field(t_reg_idx'(i), rd));
            end
        end
    endtask

    task automatic program_box(int xl, int yl, int zh, int zl, int thr);
        write_reg(REG_X_LIMIT, dirty(xl, LIM_BITS));
        write_reg(REG_Y_LIMIT, dirty(yl, LIM_BITS));
        write_reg(REG_Z_HIGH, dirty(zh, COORD_BITS));
        write_reg(REG_Z_LOW, dirty(zl, COORD_BITS));
        write_reg(REG_THRESH, dirty(thr, THR_BITS));
        write_reg(t_reg_idx'($urandom_range(NUM_REGS, (1 << $bits(t_reg_idx)) - 1)), $urandom);
        check_regs();
    endtask

    // stop sending and wait for every outstanding report, then let the block settle
    task automatic drain(int settle);
        int spin;
        spin = 0;
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        if (expected_reports.size() != 0) begin
            errors++;
            $display("%0t %0d report(s) never arrived: expected obstacle %0d slot %0d count %0d",
                     $time, expected_reports.size(), expected_reports[0].obstacle,
                     expected_reports[0].slot, expected_reports[0].count);
            expected_reports.delete();
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic send_point(t_point p, bit typed = 1'b0, t_det_report want = '0);
        t_det_report rep;
        while (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, p.seg_label, p.z_mm, p.y_mm, p.x_mm};
        s_tlast <= p.frame_end;
        do @(posedge i_clk); while (!s_tready);
        rep = take_point(p);
        points_sent++;
        if (p.frame_end) expected_reports.insert(expected_reports.size(), typed ? want : rep);
    endtask

    task automatic play_frame(t_frame_kind kind, inout int sent);
        logic [LABEL_BITS-1:0] pool [8];
        logic [LABEL_BITS-1:0] lab;
        int npool, npts, ndist, base;
        t_point p;
        npool = (kind == FRAME_DENSE) ? $urandom_range(1, 3) : $urandom_range(1, 8);
        npts = (kind == FRAME_DENSE) ? $urandom_range(10, 40) : $urandom_range(1, 20);
        ndist = MAX_CLUSTERS + $urandom_range(0, 3);
        base = $urandom_range(0, 65535);
        if (kind == FRAME_CROWDED) npts = ndist + $urandom_range(0, 4);
        for (int k = 0; k < 8; k++) pool[k] = LABEL_BITS'($urandom);
        for (int k = 0; k < npts; k++) begin
            if (kind != FRAME_CROWDED) lab = pool[$urandom_range(0, npool - 1)];
            else if (k < ndist) lab = LABEL_BITS'(base + k);
            else lab = LABEL_BITS'(base + $urandom_range(0, ndist - 1));
            p = rand_point(lab, kind == FRAME_DENSE);
            p.frame_end = (k == npts - 1);
            send_point(p);
        end
        sent += npts;
    endtask

    always @(posedge i_clk) begin
        t_det_report got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[5:0], m_tdata[22:6], m_tdata[23]};
            frames_closed++;
            if (got.obstacle) obstacle_frames++;
            if (got.overflow) overflow_frames++;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t unexpected report: obstacle %0d slot %0d count %0d overflow %0d",
                         $time, got.obstacle, got.slot, got.count, got.overflow);
            end else begin
                want = expected_reports.pop_front();
                if (got.obstacle !== want.obstacle) begin
                    errors++;
                    $display("%0t obstacle: expected %0d got %0d", $time,
                             want.obstacle, got.obstacle);
                end
                if (got.slot !== want.slot) begin
                    errors++;
                    $display("%0t cluster_slot: expected %0d got %0d", $time, want.slot, got.slot);
                end
                if (got.count !== want.count) begin
                    errors++;
                    $display("%0t box_count: expected %0d got %0d", $time, want.count, got.count);
                end
                if (got.overflow !== want.overflow) begin
                    errors++;
                    $display("%0t slot_overflow: expected %0d got %0d", $time,
                             want.overflow, got.overflow);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int sent;
        // directed table: box edges, field extremes, empty box, slot order
        add_row(pt_row(100, 0, 0, 16'h0007, 1'b1, 1'b1, '0));
        add_row(pt_row(0, 0, 0, 16'hFFFF, 1'b0));
        add_row(pt_row(2499, 699, 1999, 16'hFFFF, 1'b0));
        add_row(pt_row(2500, 0, 0, 16'hFFFF, 1'b0));
        add_row(pt_row(1, -699, -499, 16'h0000, 1'b0));
        add_row(pt_row(524287, -524288, -524288, 16'h8000, 1'b0));
        add_row(pt_row(-524288, 524287, 524287, 16'h8000, 1'b0));
        add_row(pt_row(10, 700, 0, 16'h0001, 1'b0));
        add_row(pt_row(10, -700, 0, 16'h0001, 1'b0));
        add_row(pt_row(10, 0, -500, 16'h0001, 1'b0));
        add_row(pt_row(10, 0, 2000, 16'h0001, 1'b0));
        add_row(pt_row(10, 0, 0, 16'hFFFF, 1'b1));
        add_row(cfg_row(REG_THRESH, 0));
        add_row(pt_row(5, 5, 5, 16'h0003, 1'b0));
        add_row(pt_row(-5, 5, 5, 16'h0004, 1'b0));
        add_row(pt_row(5, 5, 5, 16'h0004, 1'b1, 1'b1, {1'b1, 6'd0, 17'd1, 1'b0}));
        add_row(cfg_row(REG_X_LIMIT, 0));
        add_row(pt_row(1, 0, 0, 16'h0009, 1'b1, 1'b1, '0));
        add_row(cfg_row(REG_X_LIMIT, 524287));
        add_row(cfg_row(REG_Y_LIMIT, 524287));
        add_row(cfg_row(REG_Z_HIGH, 524287));
        add_row(cfg_row(REG_Z_LOW, -524288));
        add_row(pt_row(524286, -524287, -524287, 16'h00AA, 1'b0));
        add_row(pt_row(1, 524286, 524286, 16'h00BB, 1'b0));
        add_row(pt_row(524287, 0, 0, 16'h00BB, 1'b0));
        add_row(pt_row(5, 0, -524288, 16'h00CC, 1'b1, 1'b1, {1'b1, 6'd1, 17'd1, 1'b0}));
        add_row(cfg_row(REG_Z_HIGH, -524288));
        add_row(cfg_row(REG_Z_LOW, 524287));
        add_row(cfg_row(REG_SPARE, 12345));
        add_row(pt_row(5, 0, 0, 16'h0001, 1'b1, 1'b1, '0));
        add_row(cfg_row(REG_Z_HIGH, 2000));
        add_row(cfg_row(REG_Z_LOW, -500));
        add_row(pt_row(-1, 0, 0, 16'h0011, 1'b0));
        add_row(pt_row(-1, 0, 0, 16'h0022, 1'b0));
        add_row(pt_row(3, 3, 3, 16'h0033, 1'b0));
        add_row(pt_row(3, 3, 3, 16'h0033, 1'b1, 1'b1, {1'b1, 6'd2, 17'd2, 1'b0}));

        set_idling(IDLE_NONE);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain(DRAIN_CYCLES);
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
                check_regs();
            end else begin
                send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            int zl;
            drain(DRAIN_CYCLES);
            zl = int'($urandom_range(0, 1300)) - 800;
            case (ph)
                0: program_box(2500, 700, 2000, -500, 3);
                1: program_box(524287, 524287, 524287, -524288, int'(COUNT_MAX));
                2: program_box(0, 0, -524288, 524287, 0);
                4: program_box(524287, 524287, 524287, -524288, 1);
                default: program_box($urandom_range(0, 4000), $urandom_range(0, 1200),
                                     zl + int'($urandom_range(0, 2500)), zl,
                                     $urandom_range(0, 4));
            endcase
            set_idling(t_idle_mode'(ph % 4));
            sent = 0;
            while (sent < PHASE_POINTS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:        play_frame(FRAME_CROWDED, sent);
                    3, 4, 5, 6, 7:  play_frame(FRAME_DENSE, sent);
                    default:        play_frame(FRAME_SPARSE, sent);
                endcase
                if ($urandom_range(0, 5) == 0) drain(0);
            end
        end

        drain(DRAIN_CYCLES);
        $display("%0d points in %0d frames over the directed table and six box settings",
                 points_sent, frames_closed);
        $display("%0d obstacle reports, %0d frames with slot overflow, four idling modes",
                 obstacle_frames, overflow_frames);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
